/* rtl/slfb_pkg.sv */
// ----------------------------------------------------------------------------
// slfb_pkg
// Shared widths, register codes, reset values and types of the seam line
// feather blend.
// ----------------------------------------------------------------------------
`default_nettype none

package slfb_pkg;

   // Field widths
   localparam int POS_W      = 12;
   localparam int PIX_W      = 8;
   localparam int MAX_DIM    = 4096;

   // Register widths and fixed point layout
   localparam int SLOPE_W    = 24;
   localparam int ICPT_W     = 32;
   localparam int HALF_W     = 8;
   localparam int CW_W       = 17;
   localparam int GAIN_W     = 18;
   localparam int FRAC_W     = 16;
   localparam int ACC_FRAC_W = 2 * FRAC_W;

   // Datapath widths
   localparam int PROD1_W    = SLOPE_W + POS_W + 1;
   localparam int DIST_W     = PROD1_W + 1;
   localparam int BAND_D_W   = HALF_W + FRAC_W + 1;
   localparam int PROD2_W    = GAIN_W + BAND_D_W;
   localparam int WEIGHT_W   = PROD2_W + 1;
   localparam int DIFF_W     = PIX_W + 1;
   localparam int MIX_W      = WEIGHT_W + DIFF_W;
   localparam int BLEND_W    = MIX_W + 1;
   localparam int RES_W      = BLEND_W - ACC_FRAC_W + 1;

   localparam logic signed [BLEND_W:0] ROUND_HALF =
      (BLEND_W + 1)'(64'd1 << (ACC_FRAC_W - 1));
   localparam logic [PIX_W-1:0] PIX_MAX = '1;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERCEPT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_WEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN          = 3'd4;

   localparam logic signed [SLOPE_W-1:0] RST_SLOPE         = '0;
   localparam logic signed [ICPT_W-1:0]  RST_INTERCEPT     = '0;
   localparam logic [HALF_W-1:0]         RST_HALF_WIDTH    = 8'd30;
   localparam logic [CW_W-1:0]           RST_CENTER_WEIGHT = 17'd32768;
   localparam logic signed [GAIN_W-1:0]  RST_GAIN          = 18'sd546;

   typedef enum logic [1:0] {
      ZONE_PROFILE   = 2'd0,
      ZONE_BLEND     = 2'd1,
      ZONE_UNTOUCHED = 2'd2
   } zone_type;

   typedef struct packed {
      logic signed [SLOPE_W-1:0] slope;
      logic signed [ICPT_W-1:0]  intercept;
      logic [HALF_W-1:0]         half_width;
      logic [CW_W-1:0]           center_weight;
      logic signed [GAIN_W-1:0]  gain;
   } cfg_type;

   // Hand-over from the distance stages to the mixing stages
   typedef struct packed {
      zone_type                  zone;
      logic signed [PROD2_W-1:0] prod;
      logic [PIX_W-1:0]          prof;
      logic signed [DIFF_W-1:0]  diff;
   } dist_type;

endpackage

`default_nettype wire

/* rtl/slfb_if.sv */
// ----------------------------------------------------------------------------
// slfb_req_if / slfb_rsp_if
// Valid/ready channels for pixel requests and blend responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface slfb_req_if;
   import slfb_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] column;
   logic [POS_W-1:0] row;
   logic [PIX_W-1:0] profile_pixel;
   logic [PIX_W-1:0] center_pixel;

   modport source (output valid, column, row, profile_pixel, center_pixel,
                   input ready);
   modport sink   (input valid, column, row, profile_pixel, center_pixel,
                   output ready);
endinterface

interface slfb_rsp_if;
   import slfb_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_pixel;
   logic             write_enable;
   logic [1:0]       zone;

   modport source (output valid, out_pixel, write_enable, zone, input ready);
   modport sink   (input valid, out_pixel, write_enable, zone, output ready);
endinterface

`default_nettype wire

/* rtl/slfb_csr.sv */
// ----------------------------------------------------------------------------
// slfb_csr
// Configuration registers of the seam line and blending band.
// ----------------------------------------------------------------------------
`default_nettype none

module slfb_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [slfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [slfb_pkg::CSR_DATA_W-1:0] csr_wdata,
   output slfb_pkg::cfg_type                    cfg
);
   import slfb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Decode a write; unknown indexes leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLOPE:         cfg_in.slope         = csr_wdata[SLOPE_W-1:0];
            CSR_INTERCEPT:     cfg_in.intercept     = csr_wdata[ICPT_W-1:0];
            CSR_HALF_WIDTH:    cfg_in.half_width    = csr_wdata[HALF_W-1:0];
            CSR_CENTER_WEIGHT: cfg_in.center_weight = csr_wdata[CW_W-1:0];
            CSR_GAIN:          cfg_in.gain          = csr_wdata[GAIN_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slope         <= RST_SLOPE;
         cfg_ff.intercept     <= RST_INTERCEPT;
         cfg_ff.half_width    <= RST_HALF_WIDTH;
         cfg_ff.center_weight <= RST_CENTER_WEIGHT;
         cfg_ff.gain          <= RST_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/slfb_dist.sv */
// ----------------------------------------------------------------------------
// slfb_dist
// Stages one to three: seam distance, zone decision and gain product.
// ----------------------------------------------------------------------------
`default_nettype none

module slfb_dist (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire slfb_pkg::cfg_type cfg,
   slfb_req_if.sink          req_if,
   output logic              out_valid,
   input  wire logic         out_ready,
   output slfb_pkg::dist_type out_data
);
   import slfb_pkg::*;

   logic adv1, adv2, adv3;
   logic in_image;

   logic signed [SLOPE_W-1:0]  slope_s;
   logic signed [ICPT_W-1:0]   icpt_s;
   logic signed [GAIN_W-1:0]   gain_s;
   logic signed [POS_W:0]      col_s;
   logic signed [POS_W+FRAC_W:0] row_term;
   logic signed [BAND_D_W-1:0] t_s;
   logic signed [BAND_D_W-1:0] d_band;

   // Stage 1: slope times column
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [PROD1_W-1:0] s1_prod_ff, s1_prod_in;
   logic [POS_W-1:0]          s1_row_ff;
   logic [PIX_W-1:0]          s1_prof_ff, s1_cent_ff;
   logic                      s1_in_image_ff;

   // Stage 2: full distance
   logic                      s2_valid_ff, s2_valid_in;
   logic signed [DIST_W-1:0]  s2_d_ff, s2_d_in;
   logic [PIX_W-1:0]          s2_prof_ff, s2_cent_ff;
   logic                      s2_in_image_ff;

   // Stage 3: zone and gain times distance
   logic                      s3_valid_ff, s3_valid_in;
   dist_type                  s3_data_ff, s3_data_in;

   assign slope_s = cfg.slope;
   assign icpt_s  = cfg.intercept;
   assign gain_s  = cfg.gain;

   // Advance a stage when it is empty or the next one moves
   assign adv3 = !s3_valid_ff || out_ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_if.ready = adv1;

   assign s1_valid_in = adv1 ? req_if.valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff  : s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff  : s3_valid_ff;

   // Stage 1 datapath
   assign col_s      = $signed({1'b0, req_if.column});
   assign s1_prod_in = slope_s * col_s;
   assign in_image   = (32'(req_if.column) < MAX_DIM) && (32'(req_if.row) < MAX_DIM);

   // Stage 2 datapath
   assign row_term = $signed({1'b0, s1_row_ff, {FRAC_W{1'b0}}});
   assign s2_d_in  = s1_prod_ff + icpt_s - row_term;

   // Stage 3 datapath: classify against the band, form gain*d
   assign t_s    = $signed({1'b0, cfg.half_width, {FRAC_W{1'b0}}});
   assign d_band = $signed(s2_d_ff[BAND_D_W-1:0]);

   always_comb begin
      s3_data_in.prof = s2_prof_ff;
      s3_data_in.diff = $signed({1'b0, s2_cent_ff}) - $signed({1'b0, s2_prof_ff});
      s3_data_in.prod = gain_s * d_band;
      if (!s2_in_image_ff) begin
         s3_data_in.zone = ZONE_UNTOUCHED;
      end else if (s2_d_ff <= -t_s) begin
         s3_data_in.zone = ZONE_PROFILE;
      end else if (s2_d_ff < t_s) begin
         s3_data_in.zone = ZONE_BLEND;
      end else begin
         s3_data_in.zone = ZONE_UNTOUCHED;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload; hold while stalled
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_prod_ff     <= s1_prod_in;
         s1_row_ff      <= req_if.row;
         s1_prof_ff     <= req_if.profile_pixel;
         s1_cent_ff     <= req_if.center_pixel;
         s1_in_image_ff <= in_image;
      end
      if (adv2) begin
         s2_d_ff        <= s2_d_in;
         s2_prof_ff     <= s1_prof_ff;
         s2_cent_ff     <= s1_cent_ff;
         s2_in_image_ff <= s1_in_image_ff;
      end
      if (adv3) begin
         s3_data_ff     <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

`default_nettype wire

/* rtl/slfb_mix.sv */
// ----------------------------------------------------------------------------
// slfb_mix
// Stages four to six: blend weight, weighted difference, round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module slfb_mix (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire slfb_pkg::cfg_type  cfg,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire slfb_pkg::dist_type in_data,
   slfb_rsp_if.source         rsp_if
);
   import slfb_pkg::*;

   logic adv4, adv5, adv6;

   logic signed [PROD2_W-1:0]   in_prod;
   logic signed [BLEND_W-1:0]   blend_v;
   logic signed [BLEND_W:0]     blend_r;
   logic [RES_W-1:0]            res;

   // Stage 4: weight a
   logic                       s4_valid_ff, s4_valid_in;
   logic signed [WEIGHT_W-1:0] s4_a_ff, s4_a_in;
   logic signed [DIFF_W-1:0]   s4_diff_ff;
   logic [PIX_W-1:0]           s4_prof_ff;
   zone_type                   s4_zone_ff;

   // Stage 5: a times (center - profile)
   logic                       s5_valid_ff, s5_valid_in;
   logic signed [MIX_W-1:0]    s5_m_ff, s5_m_in;
   logic [PIX_W-1:0]           s5_prof_ff;
   zone_type                   s5_zone_ff;

   // Stage 6: output register
   logic                       s6_valid_ff, s6_valid_in;
   logic [PIX_W-1:0]           s6_pix_ff, s6_pix_in;
   zone_type                   s6_zone_ff;

   assign adv6 = !s6_valid_ff || rsp_if.ready;
   assign adv5 = !s5_valid_ff || adv6;
   assign adv4 = !s4_valid_ff || adv5;
   assign in_ready = adv4;

   assign s4_valid_in = adv4 ? in_valid    : s4_valid_ff;
   assign s5_valid_in = adv5 ? s4_valid_ff : s5_valid_ff;
   assign s6_valid_in = adv6 ? s5_valid_ff : s6_valid_ff;

   // Stage 4 datapath
   assign in_prod = in_data.prod;
   assign s4_a_in = in_prod + $signed({1'b0, cfg.center_weight, {FRAC_W{1'b0}}});

   // Stage 5 datapath
   assign s5_m_in = s4_a_ff * s4_diff_ff;

   // Stage 6 datapath: add profile, round half up, clamp to pixel range
   assign blend_v = $signed({1'b0, s5_prof_ff, {ACC_FRAC_W{1'b0}}}) + s5_m_ff;
   assign blend_r = blend_v + ROUND_HALF;
   assign res     = blend_r[BLEND_W:ACC_FRAC_W];

   always_comb begin
      case (s5_zone_ff)
         ZONE_PROFILE: s6_pix_in = s5_prof_ff;
         ZONE_BLEND: begin
            if (blend_v < 0) begin
               s6_pix_in = '0;
            end else if (res > RES_W'(PIX_MAX)) begin
               s6_pix_in = PIX_MAX;
            end else begin
               s6_pix_in = res[PIX_W-1:0];
            end
         end
         default: s6_pix_in = '0;
      endcase
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
         s6_valid_ff <= s6_valid_in;
      end
   end

   // Payload; hold while stalled
   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_a_ff    <= s4_a_in;
         s4_diff_ff <= in_data.diff;
         s4_prof_ff <= in_data.prof;
         s4_zone_ff <= in_data.zone;
      end
      if (adv5) begin
         s5_m_ff    <= s5_m_in;
         s5_prof_ff <= s4_prof_ff;
         s5_zone_ff <= s4_zone_ff;
      end
      if (adv6) begin
         s6_pix_ff  <= s6_pix_in;
         s6_zone_ff <= s5_zone_ff;
      end
   end

   assign rsp_if.valid        = s6_valid_ff;
   assign rsp_if.out_pixel    = s6_pix_ff;
   assign rsp_if.write_enable = (s6_zone_ff != ZONE_UNTOUCHED);
   assign rsp_if.zone         = s6_zone_ff;

endmodule

`default_nettype wire

/* rtl/seam_line_feather_blend_top.sv */
// ----------------------------------------------------------------------------
// seam_line_feather_blend_top
// Feathered stitching of a profile image onto a center image along a seam.
// ----------------------------------------------------------------------------
// Each request transaction carries one pixel position with its profile and
// center gray values and yields exactly one response transaction, in order.
// The block takes one pixel per clock while the response is not stalled and
// has six register stages, with the slope product, the gain product and the
// weighted difference product each in a stage of its own. A stalled response
// holds the pipeline only as far back as it is full, so bubbles are squeezed
// out. The user must write configuration registers through the csr port only
// while no transaction is in flight; the block itself does not enforce this.
`default_nettype none

module seam_line_feather_blend_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   slfb_req_if.sink                            req_if,
   slfb_rsp_if.source                          rsp_if,
   input  wire logic                           csr_we,
   input  wire logic [slfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [slfb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import slfb_pkg::*;

   cfg_type  cfg;
   logic     dist_valid;
   logic     dist_ready;
   dist_type dist_data;

   slfb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slfb_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_if    (req_if),
      .out_valid (dist_valid),
      .out_ready (dist_ready),
      .out_data  (dist_data)
   );

   slfb_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (dist_valid),
      .in_ready (dist_ready),
      .in_data  (dist_data),
      .rsp_if   (rsp_if)
   );

   // Pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("response valid after reset");

   // A pixel that is not written goes out as zero
   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.write_enable) |-> (rsp_if.out_pixel == '0))
      else $error("unwritten pixel is not zero");

   // Write enable follows the zone
   a_we_zone: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.write_enable == (rsp_if.zone != ZONE_UNTOUCHED)))
      else $error("write enable disagrees with zone");

   // Mid-pipeline hand-over holds its data while the mixing stages stall
   a_dist_hold: assert property (@(posedge clock) disable iff (reset)
      (dist_valid && !dist_ready) |=> (dist_valid && $stable(dist_data)))
      else $error("distance hand-over lost or changed under stall");

endmodule

`default_nettype wire
